// ----- sv/wbps_pkg.sv -----
// Package for the wildcard byte pattern scanner.
// Holds the register map codes, the pattern configuration type and fixed sizes.
// No dependencies; the scanner top level and the cell import it.
package wbps_pkg;

    // Number of pattern positions that the registers can describe.
    localparam int PAT_POSITIONS = 16;

    // Register indexes on the configuration port (byte address is 8 * index).
    localparam logic [1:0] REG_PAT_LO  = 2'd0;
    localparam logic [1:0] REG_PAT_HI  = 2'd1;
    localparam logic [1:0] REG_WILD    = 2'd2;
    localparam logic [1:0] REG_PAT_LEN = 2'd3;

    // Pattern bytes and wildcard bits as seen by every cell of the window.
    typedef struct packed {
        logic [8*PAT_POSITIONS-1:0] bytes;
        logic [PAT_POSITIONS-1:0]   wild;
    } pat_cfg_t;

endpackage

// ----- sv/wbps_ifs.sv -----
// Handshake interfaces of the wildcard byte pattern scanner.
// wbps_byte_if carries region bytes, wbps_result_if carries search results.
// Depends on nothing.
interface wbps_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       region_end;

    modport source (output valid, output data_byte, output region_end, input ready);
    modport sink   (input valid, input data_byte, input region_end, output ready);
endinterface

interface wbps_result_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [31:0] match_offset;

    modport source (output valid, output found, output match_offset, input ready);
    modport sink   (input valid, input found, input match_offset, output ready);
endinterface

// ----- sv/wildcard_byte_pattern_scanner.sv -----
// Top level of the wildcard byte pattern scanner.
// Depends on wbps_pkg, the interfaces in wbps_ifs.sv and the cell wbps_cell.
//
// Usage: region bytes arrive on byte_in (data_byte, region_end marks the last
// byte of a region). The block finds the first place in each region where the
// configured pattern matches, wildcard positions matching any byte, and sends
// one request on result_out: found with the offset of the match's first byte,
// or found low with offset zero when the region ends without a match. Bytes
// after a match give nothing until the region ends.
// The pattern is set over the APB port: pattern bytes 0..7 at 0x00, bytes
// 8..15 at 0x08, wildcard mask at 0x10, pattern length at 0x18. Write it only
// while no byte is in flight.
// Throughput is one byte per cycle while the skid slot is empty. A row of
// MAX_PATTERN cells holds the window; each cell compares its incoming byte
// in the accept cycle, and the result is registered in the output stage.
// The output stage has a skid register: byte_in.ready drops only while two
// results wait, the skid slot being full.
// Reset empties the window, the output stage and the region counters and loads
// the register defaults (length one, pattern and mask zero).
module wildcard_byte_pattern_scanner
    import wbps_pkg::*;
#(
    parameter int MAX_PATTERN = 16,
    parameter int OFFSET_BITS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    wbps_byte_if.sink            byte_in,
    wbps_result_if.source        result_out,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [63:0]          pwdata,
    output logic [63:0]          prdata,
    output logic                 pready
);

    // Width that holds both the five bit length register and MAX_PATTERN.
    localparam int LW = ($clog2(MAX_PATTERN + 1) > 5) ? $clog2(MAX_PATTERN + 1) : 5;

    // Configuration registers.
    logic [63:0] pat_lo_reg;
    logic [63:0] pat_hi_reg;
    logic [15:0] wild_reg;
    logic [4:0]  len_raw_reg;

    // Region state.
    logic [LW-1:0]          fill_reg, fill_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic                   done_reg, done_next;

    // Output stage and skid slot.
    logic        out_valid_reg, out_valid_next;
    logic        out_found_reg, out_found_next;
    logic [31:0] out_off_reg, out_off_next;
    logic        skid_valid_reg, skid_valid_next;
    logic        skid_found_reg, skid_found_next;
    logic [31:0] skid_off_reg, skid_off_next;

    logic                   accept;
    logic                   cfg_write;
    logic [LW-1:0]          len;
    pat_cfg_t               pat;
    logic [7:0]             win [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] hit;
    logic                   match;
    logic                   res_valid;
    logic [OFFSET_BITS-1:0] start;
    logic [63:0]            start_wide;
    logic [31:0]            start_clip;
    logic                   take;
    logic                   push;

    //------------------------------------------------------------------
    // Configuration port
    //------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_lo_reg  <= '0;
            pat_hi_reg  <= '0;
            wild_reg    <= '0;
            len_raw_reg <= 5'd1;
        end
        else if (cfg_write)
        begin
            case (paddr[4:3])
                REG_PAT_LO:  pat_lo_reg  <= pwdata;
                REG_PAT_HI:  pat_hi_reg  <= pwdata;
                REG_WILD:    wild_reg    <= pwdata[15:0];
                REG_PAT_LEN: len_raw_reg <= pwdata[4:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:3])
            REG_PAT_LO:  prdata = pat_lo_reg;
            REG_PAT_HI:  prdata = pat_hi_reg;
            REG_WILD:    prdata = {48'd0, wild_reg};
            REG_PAT_LEN: prdata = {59'd0, len_raw_reg};
            default:     prdata = '0;
        endcase
    end

    // A length of zero acts as one; a length beyond the window is clipped.
    always_comb
    begin
        if (len_raw_reg == 5'd0)
        begin
            len = LW'(1);
        end
        else if (LW'(len_raw_reg) > LW'(MAX_PATTERN))
        begin
            len = LW'(MAX_PATTERN);
        end
        else
        begin
            len = LW'(len_raw_reg);
        end
    end

    assign pat.bytes = {pat_hi_reg, pat_lo_reg};
    assign pat.wild  = wild_reg;

    //------------------------------------------------------------------
    // Window: a row of cells, newest byte entering the highest cell.
    //------------------------------------------------------------------
    assign byte_in.ready = !skid_valid_reg;
    assign accept        = byte_in.valid && byte_in.ready;

    for (genvar w = 0; w < MAX_PATTERN; w++)
    begin : g_cell
        logic [7:0] din;
        if (w == MAX_PATTERN - 1)
        begin : g_head
            assign din = byte_in.data_byte;
        end
        else
        begin : g_body
            assign din = win[w + 1];
        end

        wbps_cell #(
            .MAX_PATTERN (MAX_PATTERN),
            .CELL_IDX    (w),
            .LW          (LW)
        ) u_cell (
            .clk   (clk),
            .shift (accept),
            .din   (din),
            .pat   (pat),
            .len   (len),
            .q     (win[w]),
            .hit   (hit[w])
        );
    end

    //------------------------------------------------------------------
    // Region bookkeeping and result formation.
    //------------------------------------------------------------------
    always_comb
    begin
        fill_next = (fill_reg < LW'(MAX_PATTERN)) ? fill_reg + LW'(1) : fill_reg;
        pos_next  = (pos_reg != '1) ? pos_reg + OFFSET_BITS'(1) : pos_reg;

        // Compare only once the whole pattern lies inside this region.
        match     = !done_reg && (fill_next >= len) && (&hit);
        res_valid = match || (byte_in.region_end && !done_reg);

        // The current byte sits at pos_reg; the match starts len-1 bytes back.
        start      = pos_reg - (OFFSET_BITS'(len) - OFFSET_BITS'(1));
        start_wide = 64'(start);
        start_clip = (start_wide[63:32] != 32'd0) ? 32'hFFFF_FFFF : start_wide[31:0];

        done_next = done_reg || match;
        if (byte_in.region_end)
        begin
            fill_next = '0;
            pos_next  = '0;
            done_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            pos_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (accept)
        begin
            fill_reg <= fill_next;
            pos_reg  <= pos_next;
            done_reg <= done_next;
        end
    end

    //------------------------------------------------------------------
    // Output register with a skid slot behind it.
    //------------------------------------------------------------------
    assign take = out_valid_reg && result_out.ready;
    assign push = accept && res_valid;

    always_comb
    begin
        out_valid_next  = out_valid_reg && !take;
        out_found_next  = out_found_reg;
        out_off_next    = out_off_reg;
        skid_valid_next = skid_valid_reg;
        skid_found_next = skid_found_reg;
        skid_off_next   = skid_off_reg;

        if (skid_valid_reg)
        begin
            // No new byte is taken while the skid slot is full.
            if (take)
            begin
                out_valid_next  = 1'b1;
                out_found_next  = skid_found_reg;
                out_off_next    = skid_off_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !take)
            begin
                skid_valid_next = 1'b1;
                skid_found_next = match;
                skid_off_next   = match ? start_clip : 32'd0;
            end
            else
            begin
                out_valid_next = 1'b1;
                out_found_next = match;
                out_off_next   = match ? start_clip : 32'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_found_reg  <= out_found_next;
        out_off_reg    <= out_off_next;
        skid_found_reg <= skid_found_next;
        skid_off_reg   <= skid_off_next;
    end

    assign result_out.valid        = out_valid_reg;
    assign result_out.found        = out_found_reg;
    assign result_out.match_offset = out_off_reg;

    //------------------------------------------------------------------
    // Assertions
    //------------------------------------------------------------------
`ifndef SYNTHESIS
    // The skid slot only fills behind a waiting result.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid slot holds a result while the output register is empty");

    // A match inside a region blocks any further result until the region ends.
    a_match_sets_done: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && match && !byte_in.region_end) |=> done_reg)
        else $error("match did not mark the region as done");

    // The fill count never passes the window depth.
    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= LW'(MAX_PATTERN))
        else $error("window fill count beyond the window depth");

    // A region end always leaves the next region empty.
    a_region_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && byte_in.region_end) |=> (fill_reg == '0 && pos_reg == '0 && !done_reg))
        else $error("region state not cleared after the last byte");
`endif

endmodule

// ----- sv/wbps_cell.sv -----
// One cell of the scanner's byte window.
// Holds one window byte, passes it to the older neighbor and compares the byte
// it takes in against the pattern position that its place maps to. Uses wbps_pkg.
module wbps_cell
    import wbps_pkg::*;
#(
    parameter int MAX_PATTERN = 16,
    parameter int CELL_IDX    = 0,
    parameter int LW          = 5
)
(
    input  logic          clk,
    input  logic          shift,
    input  logic [7:0]    din,
    input  pat_cfg_t      pat,
    input  logic [LW-1:0] len,
    output logic [7:0]    q,
    output logic          hit
);

    logic [7:0] byte_reg;

    // The window byte needs no reset: it is only compared once the region has
    // filled the positions in use.
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            byte_reg <= din;
        end
    end

    assign q = byte_reg;

    // Pattern position of the byte entering this cell: the newest len bytes
    // are compared, the oldest of them against position zero.
    always_comb
    begin
        int         p;
        logic [3:0] sel;
        logic [7:0] want;
        p    = CELL_IDX + int'(len) - MAX_PATTERN;
        sel  = p[3:0];
        want = pat.bytes[{sel, 3'b000} +: 8];
        if (p < 0)
        begin
            hit = 1'b1;
        end
        else if (p >= PAT_POSITIONS)
        begin
            // Positions past the registers want a zero byte, never a wildcard.
            hit = (din == 8'd0);
        end
        else
        begin
            hit = pat.wild[sel] || (din == want);
        end
    end

endmodule
